[design/lrupr_pkg.sv]
package lrupr_pkg;

  // default sizes of the frame row and of a page number
  localparam int DEFAULT_NUM_FRAMES = 8;
  localparam int DEFAULT_PAGE_BITS  = 16;

  // capacity register and fault counter
  localparam int                  CAP_BITS   = 4;
  localparam logic [CAP_BITS-1:0] CAP_RESET  = 4'd8;
  localparam int                  COUNT_BITS = 32;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic update;  // an accepted reference touches the frames
    logic clear;   // start flag: frames read as empty for this reference
    logic fill;    // frames not full: an empty cell may take the new page
  } lrupr_ctrl_t;

endpackage

[design/lrupr_cell.sv]
module lrupr_cell #(
  parameter int PAGE_BITS = lrupr_pkg::DEFAULT_PAGE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrupr_pkg::lrupr_ctrl_t ctrl,
  input  logic [PAGE_BITS-1:0]  lookup_page,
  input  logic [PAGE_BITS-1:0]  prev_page,
  input  logic                  prev_valid,
  input  logic                  next_valid,
  input  logic                  carry_in,
  output logic                  carry_out,
  output logic [PAGE_BITS-1:0]  page_q,
  output logic                  valid_eff,
  output logic                  valid_q,
  output logic                  match,
  output logic [PAGE_BITS-1:0]  tail_page
);

  logic take;

  // view of this frame for the current reference
  assign valid_eff = valid_q & ~ctrl.clear;
  assign match     = valid_eff & (page_q == lookup_page);

  // shift runs from the front until the hit frame or the end of the residents
  assign take      = ctrl.update & carry_in & (valid_eff | ctrl.fill);
  assign carry_out = carry_in & valid_eff & ~match;

  // last resident frame offers its page as the eviction candidate
  assign tail_page = (valid_eff & ~next_valid) ? page_q : '0;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= prev_valid;
    end else if (ctrl.clear) begin
      valid_q <= 1'b0;
    end
  end

  // page held in this frame
  always_ff @(posedge clk) begin
    if (take) begin
      page_q <= prev_page;
    end
  end

endmodule

[design/lru_page_replacement.sv]
// LRU page replacement unit: each accepted transaction is one page reference
// and gives exactly one result, registered in the next cycle (hit, eviction flag
// and page, saturating fault total, resident count). The lookup compares every
// frame of the cell row in parallel and the recency shift moves pages one cell
// down in the same cycle, so a new reference is taken every cycle while the
// result register is free; a stalled result stalls the request side. Capacity
// must be written through cfg_write_en only while no transaction is in flight;
// the block does not enforce this. A value above NUM_FRAMES acts as NUM_FRAMES.
module lru_page_replacement #(
  parameter int NUM_FRAMES = lrupr_pkg::DEFAULT_NUM_FRAMES,
  parameter int PAGE_BITS  = lrupr_pkg::DEFAULT_PAGE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [PAGE_BITS-1:0]                page,
  input  logic                                start_sequence,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                hit,
  output logic                                evicted,
  output logic [PAGE_BITS-1:0]                evicted_page,
  output logic [lrupr_pkg::COUNT_BITS-1:0]    fault_count,
  output logic [$clog2(NUM_FRAMES+1)-1:0]     resident_count,
  input  logic                                cfg_write_en,
  input  logic [lrupr_pkg::CAP_BITS-1:0]      cfg_write_data
);

  localparam int RES_BITS = $clog2(NUM_FRAMES + 1);
  localparam int CMP_BITS = (RES_BITS > lrupr_pkg::CAP_BITS) ? RES_BITS : lrupr_pkg::CAP_BITS;

  logic [lrupr_pkg::CAP_BITS-1:0]   capacity;
  logic [CMP_BITS-1:0]              cap_ext;
  logic [CMP_BITS-1:0]              cap_eff;
  logic [RES_BITS-1:0]              resident, resident_next, res_base;
  logic [lrupr_pkg::COUNT_BITS-1:0] faults, faults_next, faults_base;
  logic                             accept, full, hit_now, ev_now, ins_now;
  lrupr_pkg::lrupr_ctrl_t           ctrl;

  logic [NUM_FRAMES:0]   carry;
  logic [NUM_FRAMES-1:0] vld_eff, valid_vec, match_vec;
  logic [PAGE_BITS-1:0]  cell_page [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  tail_page [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  tail_or;

  // handshake: a held result blocks the request side
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrupr_pkg::CAP_RESET;
    end else if (cfg_write_en) begin
      capacity <= cfg_write_data;
    end
  end

  // effective capacity, clipped to the frame row
  assign cap_ext = CMP_BITS'(capacity);
  assign cap_eff = (cap_ext > CMP_BITS'(NUM_FRAMES)) ? CMP_BITS'(NUM_FRAMES) : cap_ext;

  // state seen by this reference after an optional start clear
  assign res_base    = start_sequence ? '0 : resident;
  assign faults_base = start_sequence ? '0 : faults;
  assign full        = CMP_BITS'(res_base) >= cap_eff;

  // broadcast to the cells
  assign ctrl.update = accept & (cap_eff != '0);
  assign ctrl.clear  = accept & start_sequence;
  assign ctrl.fill   = ~full;

  // row of frame cells, most recently used at cell 0
  assign carry[0] = 1'b1;
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    logic                 prev_valid;
    logic                 next_valid;

    if (i == 0) begin : g_head
      assign prev_page  = page;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[i-1];
      assign prev_valid = vld_eff[i-1];
    end

    if (i == NUM_FRAMES - 1) begin : g_last
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = vld_eff[i+1];
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .lookup_page (page),
      .prev_page   (prev_page),
      .prev_valid  (prev_valid),
      .next_valid  (next_valid),
      .carry_in    (carry[i]),
      .carry_out   (carry[i+1]),
      .page_q      (cell_page[i]),
      .valid_eff   (vld_eff[i]),
      .valid_q     (valid_vec[i]),
      .match       (match_vec[i]),
      .tail_page   (tail_page[i])
    );
  end

  // eviction candidate: only the last resident cell drives a non-zero page
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      tail_or = tail_or | tail_page[i];
    end
  end

  // outcome of the reference
  assign hit_now = ctrl.update & (|match_vec);
  assign ev_now  = ctrl.update & ~hit_now & full;
  assign ins_now = ctrl.update & ~hit_now & ~full;

  // saturating fault count and resident count
  assign faults_next   = (~hit_now && faults_base != '1) ? faults_base + 1'b1 : faults_base;
  assign resident_next = ins_now ? res_base + 1'b1 : res_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      faults   <= '0;
      resident <= '0;
    end else if (accept) begin
      faults   <= faults_next;
      resident <= resident_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit            <= hit_now;
      evicted        <= ev_now;
      evicted_page   <= ev_now ? tail_or : '0;
      fault_count    <= faults_next;
      resident_count <= resident_next;
    end
  end

  // a page is never held in two frames
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("page matched in more than one frame");

  // valid frames form a prefix of the row
  assert property (@(posedge clk) disable iff (rst)
      (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid frames not contiguous from the front");

  // resident counter tracks the valid flags
  assert property (@(posedge clk) disable iff (rst)
      $countones(valid_vec) == int'(resident))
    else $error("resident count out of step with frame flags");

  // on a hit the recency shift stops inside the row
  assert property (@(posedge clk) disable iff (rst)
      hit_now |-> !carry[NUM_FRAMES])
    else $error("shift ran past a hit frame");

  // a result is never both a hit and an eviction
  assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> !(hit && evicted))
    else $error("hit reported together with eviction");

endmodule
